>>> hw/rtl/pixel_mean_variance_mask_top_defines.svh
// assertion macros for the pixel mean and variance mask block
`ifndef PIXEL_MEAN_VARIANCE_MASK_TOP_DEFINES_SVH
`define PIXEL_MEAN_VARIANCE_MASK_TOP_DEFINES_SVH

// same cycle implication
`define PMVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next cycle implication
`define PMVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pmvm_pkg.sv
// package with types and constants of the pixel mean and variance mask block
`timescale 1ns / 1ps

package pmvm_pkg;

  localparam int unsigned PIXEL_COUNT_DEF = 4096;
  localparam int unsigned MAX_FRAMES_DEF  = 255;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned MASK_W  = 48;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned SQ_W    = 24;
  localparam int unsigned FC_W    = 8;
  localparam int unsigned DF_W    = 8;

  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 35;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned BIG_W   = 43;

  localparam int unsigned DIV_W     = SUM_W + 8;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [DF_W-1:0] DEV_FACTOR_RST = 8'd16;
  localparam logic            REG_DEV_FACTOR = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ACC  = 2'd1,
    CMD_MEAN = 2'd2,
    CMD_MASK = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAMES = 2'd1,
    ST_LIMIT     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/pmvm_intf.sv
// valid/ready channel interfaces for command transactions and results
`timescale 1ns / 1ps

interface pmvm_in_if;
  logic                           valid;
  logic                           ready;
  logic [pmvm_pkg::CMD_W-1:0]     command;
  logic [pmvm_pkg::IDX_W-1:0]     pixel_index;
  logic [pmvm_pkg::PIX_W-1:0]     pixel_value;
  logic                           frame_end;

  modport source (output valid, command, pixel_index, pixel_value, frame_end, input ready);
  modport sink   (input valid, command, pixel_index, pixel_value, frame_end, output ready);
endinterface

interface pmvm_out_if;
  logic                              valid;
  logic                              ready;
  logic [pmvm_pkg::MEAN_W-1:0]       mean_value;
  logic signed [pmvm_pkg::MASK_W-1:0] mask_value;
  logic [pmvm_pkg::STAT_W-1:0]       status;

  modport source (output valid, mean_value, mask_value, status, input ready);
  modport sink   (input valid, mean_value, mask_value, status, output ready);
endinterface

>>> hw/rtl/pixel_mean_variance_mask_top.sv
// per-pixel mean and variance background model with a shared multiplier sequencer
// load and accumulate pass through the read and exec states; read mean then runs the 24-step
// restoring divider and read mask runs the states M1 to M6 around the one 18x35 multiplier;
// each result waits in a pending register until the output register is free
// a new transaction is accepted only once the last result has moved to the output register
// reset clears the frame count, sets the deviation factor to 1.0; pixel sums stay unset
`timescale 1ns / 1ps
`include "pixel_mean_variance_mask_top_defines.svh"

module pixel_mean_variance_mask_top #(
  parameter int unsigned PIXEL_COUNT = pmvm_pkg::PIXEL_COUNT_DEF,
  parameter int unsigned MAX_FRAMES  = pmvm_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmvm_pkg::APB_AW-1:0]   paddr,
  input  logic [pmvm_pkg::APB_DW-1:0]   pwdata,
  output logic [pmvm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  pmvm_in_if.sink                       in_i,
  pmvm_out_if.source                    out_o
);

  localparam int unsigned AW  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned IXW = (AW > pmvm_pkg::IDX_W) ? AW : pmvm_pkg::IDX_W;

  localparam int unsigned SUM_W  = pmvm_pkg::SUM_W;
  localparam int unsigned SQ_W   = pmvm_pkg::SQ_W;
  localparam int unsigned FC_W   = pmvm_pkg::FC_W;
  localparam int unsigned PIX_W  = pmvm_pkg::PIX_W;
  localparam int unsigned DF_W   = pmvm_pkg::DF_W;
  localparam int unsigned MASK_W = pmvm_pkg::MASK_W;
  localparam int unsigned MEAN_W = pmvm_pkg::MEAN_W;
  localparam int unsigned A_W    = pmvm_pkg::MUL_A_W;
  localparam int unsigned B_W    = pmvm_pkg::MUL_B_W;
  localparam int unsigned P_W    = pmvm_pkg::MUL_P_W;
  localparam int unsigned BIG_W  = pmvm_pkg::BIG_W;
  localparam int unsigned DIV_W  = pmvm_pkg::DIV_W;
  localparam int unsigned CNT_W  = pmvm_pkg::CNT_W;

  localparam logic [FC_W-1:0]  FC_LIMIT = FC_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(pmvm_pkg::DIV_STEPS - 1);
  localparam logic signed [MASK_W-1:0] MASK_MAX = {1'b0, {(MASK_W-1){1'b1}}};
  localparam logic signed [MASK_W-1:0] MASK_MIN = {1'b1, {(MASK_W-1){1'b0}}};

  // control state
  pmvm_pkg::state_e  state_q, state_d;
  logic [FC_W-1:0]   fc_q;
  logic [DF_W-1:0]   df_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  cnt_q;

  // transaction registers
  pmvm_pkg::cmd_e    cmd_q;
  logic [pmvm_pkg::IDX_W-1:0] idx_q;
  logic [PIX_W-1:0]  pix_q;
  logic              fend_q;
  logic              inside_q;

  // memories
  logic [SUM_W-1:0]  sum_mem [PIXEL_COUNT];
  logic [SQ_W-1:0]   sq_mem  [PIXEL_COUNT];
  logic [SUM_W-1:0]  rd_sum_q;
  logic [SQ_W-1:0]   rd_sq_q;

  // shared multiplier and working registers
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   mul_p;
  logic signed [P_W-1:0]   acc_q;
  logic signed [A_W-1:0]   dvt_q;
  logic signed [B_W-1:0]   var_q;
  logic signed [BIG_W-1:0] big_q;

  // divider
  logic [FC_W-1:0]   rem_q;
  logic [DIV_W-1:0]  dq_q;
  logic [FC_W:0]     div_trial;
  logic [FC_W:0]     div_rem;
  logic              div_ge;
  logic [DIV_W-1:0]  dq_d;

  // pending and output results
  logic [MEAN_W-1:0]        pend_mean_q;
  logic signed [MASK_W-1:0] pend_mask_q;
  pmvm_pkg::status_e        pend_stat_q;
  logic [MEAN_W-1:0]        out_mean_q;
  logic signed [MASK_W-1:0] out_mask_q;
  pmvm_pkg::status_e        out_stat_q;

  logic              in_ready;
  logic              mem_we;
  logic              out_free;
  logic              at_limit;
  logic              no_frames;
  logic [AW-1:0]     mem_addr;
  logic [IXW-1:0]    idx_ext;
  logic [SUM_W-1:0]  sum_w;
  logic [SQ_W-1:0]   sq_w;
  logic [SUM_W:0]    sum_add;
  logic [SQ_W:0]     sq_add;
  logic [SUM_W-1:0]  wr_sum;
  logic [SQ_W-1:0]   wr_sq;
  logic signed [P_W-1:0] diff;
  logic              diff_fits;
  logic              cfg_we;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[pmvm_pkg::APB_AW-1:2] == pmvm_pkg::REG_DEV_FACTOR);
  assign prdata = (paddr[pmvm_pkg::APB_AW-1:2] == pmvm_pkg::REG_DEV_FACTOR) ?
                  pmvm_pkg::APB_DW'(df_q) : '0;

  // datapath helpers
  assign idx_ext   = IXW'(idx_q);
  assign mem_addr  = idx_ext[AW-1:0];
  assign sum_w     = inside_q ? rd_sum_q : '0;
  assign sq_w      = inside_q ? rd_sq_q : '0;
  assign at_limit  = (fc_q >= FC_LIMIT);
  assign no_frames = (fc_q == '0);
  assign out_free  = !out_valid_q || out_o.ready;

  assign sum_add = {1'b0, sum_w} + (SUM_W+1)'(pix_q);
  assign sq_add  = {1'b0, sq_w} + (SQ_W+1)'(acc_q[15:0]);
  assign wr_sum  = (cmd_q == pmvm_pkg::CMD_LOAD) ? SUM_W'(pix_q) :
                   (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
  assign wr_sq   = (cmd_q == pmvm_pkg::CMD_LOAD) ? SQ_W'(acc_q[15:0]) :
                   (sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0]);

  assign mul_p = mul_a * mul_b;

  assign div_trial = {rem_q, dq_q[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, fc_q});
  assign div_rem   = div_ge ? (div_trial - {1'b0, fc_q}) : div_trial;
  assign dq_d      = {dq_q[DIV_W-2:0], div_ge};

  assign diff      = {{(P_W-BIG_W){big_q[BIG_W-1]}}, big_q} - acc_q;
  assign diff_fits = (&diff[P_W-1:MASK_W-1]) || !(|diff[P_W-1:MASK_W-1]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pmvm_pkg::S_IDLE: begin
        if (in_i.valid) state_d = pmvm_pkg::S_READ;
      end
      pmvm_pkg::S_READ: state_d = pmvm_pkg::S_EXEC;
      pmvm_pkg::S_EXEC: begin
        unique case (cmd_q)
          pmvm_pkg::CMD_LOAD,
          pmvm_pkg::CMD_ACC:  state_d = pmvm_pkg::S_DONE;
          pmvm_pkg::CMD_MEAN: state_d = no_frames ? pmvm_pkg::S_DONE : pmvm_pkg::S_DIV;
          pmvm_pkg::CMD_MASK: state_d = no_frames ? pmvm_pkg::S_DONE : pmvm_pkg::S_M1;
          default:            state_d = pmvm_pkg::S_DONE;
        endcase
      end
      pmvm_pkg::S_DIV: begin
        if (cnt_q == DIV_LAST) state_d = pmvm_pkg::S_DONE;
      end
      pmvm_pkg::S_M1:   state_d = pmvm_pkg::S_M2;
      pmvm_pkg::S_M2:   state_d = pmvm_pkg::S_M3;
      pmvm_pkg::S_M3:   state_d = pmvm_pkg::S_M4;
      pmvm_pkg::S_M4:   state_d = pmvm_pkg::S_M5;
      pmvm_pkg::S_M5:   state_d = pmvm_pkg::S_M6;
      pmvm_pkg::S_M6:   state_d = pmvm_pkg::S_DONE;
      pmvm_pkg::S_DONE: begin
        if (out_free) state_d = pmvm_pkg::S_IDLE;
      end
      default: state_d = pmvm_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      pmvm_pkg::S_IDLE: in_ready = 1'b1;
      pmvm_pkg::S_READ: begin
        mul_a = A_W'(pix_q);
        mul_b = B_W'(pix_q);
      end
      pmvm_pkg::S_EXEC: begin
        mem_we = inside_q && ((cmd_q == pmvm_pkg::CMD_LOAD) ||
                              ((cmd_q == pmvm_pkg::CMD_ACC) && !at_limit));
        mul_a  = A_W'(fc_q);
        mul_b  = B_W'(pix_q);
      end
      pmvm_pkg::S_M1: begin
        mul_a = A_W'(fc_q);
        mul_b = B_W'(sq_w);
      end
      pmvm_pkg::S_M2: begin
        mul_a = A_W'(sum_w);
        mul_b = B_W'(sum_w);
      end
      pmvm_pkg::S_M3: begin
        mul_a = dvt_q;
        mul_b = {{(B_W-A_W){dvt_q[A_W-1]}}, dvt_q};
      end
      pmvm_pkg::S_M4: begin
        mul_a = A_W'(df_q);
        mul_b = B_W'(df_q);
      end
      pmvm_pkg::S_M5: begin
        mul_a = {1'b0, acc_q[A_W-2:0]};
        mul_b = var_q;
      end
      pmvm_pkg::S_DIV,
      pmvm_pkg::S_M6,
      pmvm_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmvm_pkg::S_IDLE;
      fc_q        <= '0;
      df_q        <= pmvm_pkg::DEV_FACTOR_RST;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) df_q <= pwdata[DF_W-1:0];
      if (state_q == pmvm_pkg::S_EXEC && fend_q) begin
        if (cmd_q == pmvm_pkg::CMD_LOAD) begin
          fc_q <= FC_W'(1);
        end else if (cmd_q == pmvm_pkg::CMD_ACC && !at_limit) begin
          fc_q <= fc_q + FC_W'(1);
        end
      end
      if (state_q == pmvm_pkg::S_EXEC) begin
        cnt_q <= '0;
      end else if (state_q == pmvm_pkg::S_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == pmvm_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pixel sum memories
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[mem_addr] <= wr_sum;
      sq_mem[mem_addr]  <= wr_sq;
    end
    rd_sum_q <= sum_mem[mem_addr];
    rd_sq_q  <= sq_mem[mem_addr];
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    acc_q <= mul_p;
    if (in_ready && in_i.valid) begin
      cmd_q    <= pmvm_pkg::cmd_e'(in_i.command);
      idx_q    <= in_i.pixel_index;
      pix_q    <= in_i.pixel_value;
      fend_q   <= in_i.frame_end;
      inside_q <= (32'(in_i.pixel_index) < 32'(PIXEL_COUNT));
    end
    unique case (state_q)
      pmvm_pkg::S_EXEC: begin
        pend_mean_q <= '0;
        pend_mask_q <= '0;
        if (cmd_q == pmvm_pkg::CMD_ACC && at_limit) begin
          pend_stat_q <= pmvm_pkg::ST_LIMIT;
        end else if ((cmd_q == pmvm_pkg::CMD_MEAN || cmd_q == pmvm_pkg::CMD_MASK) &&
                     no_frames) begin
          pend_stat_q <= pmvm_pkg::ST_NO_FRAMES;
        end else begin
          pend_stat_q <= pmvm_pkg::ST_OK;
        end
        rem_q <= '0;
        dq_q  <= {sum_w, 8'b0};
      end
      pmvm_pkg::S_DIV: begin
        rem_q <= div_rem[FC_W-1:0];
        dq_q  <= dq_d;
        if (cnt_q == DIV_LAST) begin
          pend_mean_q <= (|dq_d[DIV_W-1:MEAN_W]) ? '1 : dq_d[MEAN_W-1:0];
        end
      end
      pmvm_pkg::S_M1: begin
        dvt_q <= $signed({1'b0, acc_q[A_W-2:0]}) - $signed({2'b0, sum_w});
      end
      pmvm_pkg::S_M2: var_q <= acc_q[B_W-1:0];
      pmvm_pkg::S_M3: var_q <= var_q - acc_q[B_W-1:0];
      pmvm_pkg::S_M4: big_q <= {acc_q[BIG_W-9:0], 8'b0};
      pmvm_pkg::S_M6: begin
        if (diff_fits) begin
          pend_mask_q <= diff[MASK_W-1:0];
        end else begin
          pend_mask_q <= diff[P_W-1] ? MASK_MIN : MASK_MAX;
        end
      end
      pmvm_pkg::S_DONE: begin
        if (out_free) begin
          out_mean_q <= pend_mean_q;
          out_mask_q <= pend_mask_q;
          out_stat_q <= pend_stat_q;
        end
      end
      pmvm_pkg::S_IDLE,
      pmvm_pkg::S_READ,
      pmvm_pkg::S_M5: ;
      default: ;
    endcase
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.mean_value = out_mean_q;
  assign out_o.mask_value = out_mask_q;
  assign out_o.status     = out_stat_q;

  `PMVM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, state_q == pmvm_pkg::S_READ && !in_i.ready, "accepted transaction did not start a read")
  `PMVM_ASSERT_IMP(a_div_has_frames, clk_i, rst_ni, state_q == pmvm_pkg::S_DIV, fc_q != '0, "divider running with no frames")
  `PMVM_ASSERT_IMP(a_fc_bounded, clk_i, rst_ni, 1'b1, fc_q <= FC_LIMIT, "frame count above limit")
  `PMVM_ASSERT_IMP(a_no_frames_zero, clk_i, rst_ni, out_valid_q && out_stat_q == pmvm_pkg::ST_NO_FRAMES, out_mean_q == '0 && out_mask_q == '0, "no frames result carries data")
  `PMVM_ASSERT_NXT(a_done_loads_out, clk_i, rst_ni, state_q == pmvm_pkg::S_DONE && !out_valid_q, out_valid_q, "finished result not presented")

endmodule
